// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/cpp_pkg.sv
// ---------------------------------------------------------------------------
// cpp_pkg
// Types, register codes and fixed-point helpers for the point projection core.
// ---------------------------------------------------------------------------
package cpp_pkg;

  typedef enum logic [2:0] {
    REG_FOCAL   = 3'd0,
    REG_PRIN_X  = 3'd1,
    REG_PRIN_Y  = 3'd2,
    REG_K1      = 3'd3,
    REG_K2      = 3'd4,
    REG_K3      = 3'd5,
    REG_TANG    = 3'd6,
    REG_DIST_EN = 3'd7
  } cfg_reg_t;

  localparam int DIV_STAGES = 8;

  localparam logic [63:0] FOCAL_RESET = 64'h0001_0000_0001_0000;
  localparam logic signed [41:0] ONE_Q24 = 42'sd16777216;
  localparam logic signed [31:0] PIX_INVALID = -32'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 42'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // four restoring-division steps: returns {remainder, quotient bits}
  function automatic logic [34:0] div_step4(input logic [30:0] rem_in,
                                            input logic [3:0] bits,
                                            input logic [30:0] dvs);
    logic [30:0] rem;
    logic [31:0] t;
    logic [3:0] q;
    rem = rem_in;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, dvs}) begin
        rem = 31'(t - {1'b0, dvs});
        q[i] = 1'b1;
      end else begin
        rem = t[30:0];
      end
    end
    return {rem, q};
  endfunction

  // quotient magnitude to saturated signed Q8.24
  function automatic logic signed [31:0] quot_sat(input logic [31:0] q,
                                                  input logic neg,
                                                  input logic ovf);
    logic signed [31:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) begin
        r = S32_MIN;
      end else begin
        r = $signed(32'd0 - q);
      end
    end else begin
      if (ovf || q[31]) begin
        r = S32_MAX;
      end else begin
        r = $signed(q);
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/camera_point_projection_core.sv
// ---------------------------------------------------------------------------
// camera_point_projection_core
// Pinhole projection of camera-frame points with radial/tangential lens
// distortion, fixed point, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  point in | in_valid, in_stall, point_x/y/z           | in
//  pixel out| out_valid, out_stall, pixel_u/v, point_valid | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  one item enters per cycle unless frozen; stages: input register, eight
//  4-bit radix stages of the x/z and y/z dividers, thirteen arithmetic stages
//  rst is synchronous; it empties the pipeline and loads register defaults
//  out_stall freezes the whole pipeline while out_valid is high; in_stall is high while it is frozen
//  cfg_ready is always high
module camera_point_projection_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pixel_u,
  output logic signed [31:0]  pixel_v,
  output logic                point_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cpp_pkg::cfg_reg_t   cfg_index,
  input  logic [63:0]         cfg_data
);
  import cpp_pkg::*;
  `include "assert_macros.svh"

  localparam int NV = 22;

  logic [63:0] focal;
  logic [31:0] prin_x, prin_y;
  logic signed [31:0] k1, k2, k3, p1, p2;
  logic dist_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal <= FOCAL_RESET;
      prin_x <= '0;
      prin_y <= '0;
      k1 <= '0;
      k2 <= '0;
      k3 <= '0;
      p1 <= '0;
      p2 <= '0;
      dist_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL:   focal <= cfg_data;
        REG_PRIN_X:  prin_x <= cfg_data[31:0];
        REG_PRIN_Y:  prin_y <= cfg_data[31:0];
        REG_K1:      k1 <= $signed(cfg_data[31:0]);
        REG_K2:      k2 <= $signed(cfg_data[31:0]);
        REG_K3:      k3 <= $signed(cfg_data[31:0]);
        REG_TANG: begin
          p1 <= $signed(cfg_data[63:32]);
          p2 <= $signed(cfg_data[31:0]);
        end
        REG_DIST_EN: dist_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NV-1:0] vld;
  logic adv;
  assign adv = !(vld[NV-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // input register: magnitudes, signs, overflow test
  logic [32:0] ax, ay;
  logic [30:0] dr_x [0:DIV_STAGES];
  logic [30:0] dr_y [0:DIV_STAGES];
  logic [31:0] dl_x [0:DIV_STAGES];
  logic [31:0] dl_y [0:DIV_STAGES];
  logic [31:0] dq_x [0:DIV_STAGES];
  logic [31:0] dq_y [0:DIV_STAGES];
  logic [30:0] dz   [0:DIV_STAGES];
  logic [DIV_STAGES:0] dneg_x, dneg_y, dovf_x, dovf_y, dzok;

  assign ax = point_x[31] ? 33'(33'd0 - {point_x[31], point_x}) : {1'b0, point_x};
  assign ay = point_y[31] ? 33'(33'd0 - {point_y[31], point_y}) : {1'b0, point_y};

  always_ff @(posedge clk) begin
    if (adv) begin
      dr_x[0] <= {6'd0, ax[32:8]};
      dr_y[0] <= {6'd0, ay[32:8]};
      dl_x[0] <= {ax[7:0], 24'd0};
      dl_y[0] <= {ay[7:0], 24'd0};
      dq_x[0] <= '0;
      dq_y[0] <= '0;
      dz[0] <= point_z[30:0];
      dneg_x[0] <= point_x[31];
      dneg_y[0] <= point_y[31];
      dovf_x[0] <= {7'd0, ax} >= {point_z, 8'd0};
      dovf_y[0] <= {7'd0, ay} >= {point_z, 8'd0};
      dzok[0] <= !point_z[31] && (point_z != 32'sd0);
    end
  end

  // radix-16 division stages
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [34:0] sx, sy;
    assign sx = div_step4(dr_x[k-1], dl_x[k-1][31:28], dz[k-1]);
    assign sy = div_step4(dr_y[k-1], dl_y[k-1][31:28], dz[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        dr_x[k] <= sx[34:4];
        dr_y[k] <= sy[34:4];
        dq_x[k] <= {dq_x[k-1][27:0], sx[3:0]};
        dq_y[k] <= {dq_y[k-1][27:0], sy[3:0]};
        dl_x[k] <= {dl_x[k-1][27:0], 4'd0};
        dl_y[k] <= {dl_y[k-1][27:0], 4'd0};
        dz[k] <= dz[k-1];
        dneg_x[k] <= dneg_x[k-1];
        dneg_y[k] <= dneg_y[k-1];
        dovf_x[k] <= dovf_x[k-1];
        dovf_y[k] <= dovf_y[k-1];
        dzok[k] <= dzok[k-1];
      end
    end
  end

  // carried per stage: zok and normalized coords
  logic zok_a, zok_b, zok_c, zok_d, zok_e, zok_f, zok_g, zok_h, zok_i, zok_j, zok_k;
  logic zok_l;
  logic signed [31:0] nx_a, ny_a, nx_b, ny_b, nx_c, ny_c, nx_d, ny_d, nx_e, ny_e;
  logic signed [31:0] nx_f, ny_f, nx_g, ny_g, nx_h, ny_h, nx_i, ny_i, nx_j, ny_j;
  logic signed [63:0] pxx, pyy, pxy;
  logic signed [31:0] r2_b, xx_b, yy_b, xy_b;
  logic [63:0] sq;
  logic [39:0] sq_hi;
  logic signed [63:0] prr, pk1;
  logic signed [31:0] tx_c, ty_c, r2_c, xy_c;
  logic signed [31:0] r4_d, r2_d;
  logic signed [35:0] a1_d, a1_e, a1_f, a1_g;
  logic signed [63:0] pp1xy, pp2xy, pp2tx, pp1ty;
  logic signed [63:0] pr24, pk2;
  logic signed [37:0] dx_e, dy_e, dx_f, dy_f, dx_g, dy_g, dx_h, dy_h, dx_i, dy_i;
  logic signed [31:0] r6_f;
  logic signed [35:0] a2_f, a2_g;
  logic signed [63:0] pk3;
  logic signed [31:0] rad_h;
  logic signed [63:0] pxr, pyr;
  logic signed [31:0] xd_j, yd_j;
  logic signed [64:0] pu, pv;

  assign sq = $unsigned(pxx) + $unsigned(pyy);
  assign sq_hi = sq[63:24];

  always_ff @(posedge clk) begin
    if (adv) begin
      // a: divider result to saturated Q8.24
      nx_a <= quot_sat(dq_x[DIV_STAGES], dneg_x[DIV_STAGES], dovf_x[DIV_STAGES]);
      ny_a <= quot_sat(dq_y[DIV_STAGES], dneg_y[DIV_STAGES], dovf_y[DIV_STAGES]);
      zok_a <= dzok[DIV_STAGES];
      // b: squares and cross product
      pxx <= 64'(nx_a) * 64'(nx_a);
      pyy <= 64'(ny_a) * 64'(ny_a);
      pxy <= 64'(nx_a) * 64'(ny_a);
      nx_b <= nx_a;
      ny_b <= ny_a;
      zok_b <= zok_a;
      // c: scale back to Q8.24
      r2_b <= (|sq_hi[39:31]) ? S32_MAX : $signed(sq_hi[31:0]);
      xx_b <= sat32(42'(pxx >>> 24));
      yy_b <= sat32(42'(pyy >>> 24));
      xy_b <= sat32(42'(pxy >>> 24));
      nx_c <= nx_b;
      ny_c <= ny_b;
      zok_c <= zok_b;
      // d: r2 squared, k1 term, tangential sums
      prr <= 64'(r2_b) * 64'(r2_b);
      pk1 <= 64'(k1) * 64'(r2_b);
      tx_c <= sat32(42'(r2_b) + (42'(xx_b) <<< 1));
      ty_c <= sat32(42'(r2_b) + (42'(yy_b) <<< 1));
      r2_c <= r2_b;
      xy_c <= xy_b;
      nx_d <= nx_c;
      ny_d <= ny_c;
      zok_d <= zok_c;
      // e: r4, tangential products
      r4_d <= sat32(42'(prr >>> 24));
      a1_d <= 36'(pk1 >>> 28);
      pp1xy <= 64'(p1) * 64'(xy_c);
      pp2xy <= 64'(p2) * 64'(xy_c);
      pp2tx <= 64'(p2) * 64'(tx_c);
      pp1ty <= 64'(p1) * 64'(ty_c);
      r2_d <= r2_c;
      nx_e <= nx_d;
      ny_e <= ny_d;
      zok_e <= zok_d;
      // f: r6 product, k2 term, dx/dy
      pr24 <= 64'(r2_d) * 64'(r4_d);
      pk2 <= 64'(k2) * 64'(r4_d);
      dx_e <= (38'(pp1xy >>> 28) <<< 1) + 38'(pp2tx >>> 28);
      dy_e <= 38'(pp1ty >>> 28) + (38'(pp2xy >>> 28) <<< 1);
      a1_e <= a1_d;
      nx_f <= nx_e;
      ny_f <= ny_e;
      zok_f <= zok_e;
      // g: r6
      r6_f <= sat32(42'(pr24 >>> 24));
      a2_f <= 36'(pk2 >>> 28);
      a1_f <= a1_e;
      dx_f <= dx_e;
      dy_f <= dy_e;
      nx_g <= nx_f;
      ny_g <= ny_f;
      zok_g <= zok_f;
      // h: k3 term
      pk3 <= 64'(k3) * 64'(r6_f);
      a1_g <= a1_f;
      a2_g <= a2_f;
      dx_g <= dx_f;
      dy_g <= dy_f;
      nx_h <= nx_g;
      ny_h <= ny_g;
      zok_h <= zok_g;
      // i: radial factor
      rad_h <= sat32(ONE_Q24 + 42'(a1_g) + 42'(a2_g) + 42'(pk3 >>> 28));
      dx_h <= dx_g;
      dy_h <= dy_g;
      nx_i <= nx_h;
      ny_i <= ny_h;
      zok_i <= zok_h;
      // j: apply radial factor
      pxr <= 64'(nx_i) * 64'(rad_h);
      pyr <= 64'(ny_i) * 64'(rad_h);
      dx_i <= dx_h;
      dy_i <= dy_h;
      nx_j <= nx_i;
      ny_j <= ny_i;
      zok_j <= zok_i;
      // k: distorted coords or bypass
      xd_j <= dist_en ? sat32(42'(pxr >>> 24) + 42'(dx_i)) : nx_j;
      yd_j <= dist_en ? sat32(42'(pyr >>> 24) + 42'(dy_i)) : ny_j;
      zok_k <= zok_j;
      // l: focal scaling
      pu <= 65'($signed({1'b0, focal[63:32]})) * 65'(xd_j);
      pv <= 65'($signed({1'b0, focal[31:0]})) * 65'(yd_j);
      zok_l <= zok_k;
      // output register: principal point, invalid depth
      point_valid <= zok_l;
      pixel_u <= zok_l ? sat32(42'(pu >>> 24) + $signed({10'd0, prin_x}))
                       : PIX_INVALID;
      pixel_v <= zok_l ? sat32(42'(pv >>> 24) + $signed({10'd0, prin_y}))
                       : PIX_INVALID;
    end
  end

  `ASSERT_CLK(a_hold_u, out_valid && out_stall |=> $stable(pixel_u) && out_valid, "pixel lost")
  `ASSERT_CLK(a_stall_map, in_stall == (out_valid && out_stall), "input stall mismatch")
  `ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "pipeline not emptied by reset")

endmodule

// File: test/tb_camera_point_projection_core.sv
// ---------------------------------------------------------------------------
// tb_camera_point_projection_core
// Streams camera-frame points through the projection core under several
// camera settings, with and without lens distortion, and checks every pixel
// against a fixed-point projection computed here. Sender bursts and receiver
// stalls are random, with one long output hold-off and a full drain after each phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_camera_point_projection_core;
  import cpp_pkg::*;

  typedef struct {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               ok;
  } pixel_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               fixed;
    pixel_t             px;
  } point_row_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               point_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = REG_FOCAL;
  logic [63:0]        cfg_data = '0;

  // typed expectation that travels with a directed item
  logic               fix_en = 1'b0;
  pixel_t             fix_px;

  // camera setting as seen by the predictor
  logic [63:0]        cam_focal;
  logic [31:0]        cam_cx, cam_cy;
  logic signed [31:0] cam_k1, cam_k2, cam_k3;
  logic [63:0]        cam_tang;
  logic               cam_dist;

  pixel_t             pixel_q[$];
  int                 mismatches = 0;
  logic               hold_req = 1'b0;

  camera_point_projection_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_u(pixel_u), .pixel_v(pixel_v), .point_valid(point_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_t project(input logic signed [31:0] px,
                                     input logic signed [31:0] py,
                                     input logic signed [31:0] pz);
    pixel_t r;
    longint x, y, z, nx, ny, xd, yd, fx, fy, k1, k2, k3, p1, p2;
    longint r2, r4, r6, xx, yy, xy, rad, tx, ty, dx, dy, u, v;
    logic [63:0] sq;
    x = px; y = py; z = pz;
    if (z <= 0) begin
      r.u = -32'sd65536;
      r.v = -32'sd65536;
      r.ok = 1'b0;
      return r;
    end
    nx = clamp32((x * 64'sd16777216) / z);
    ny = clamp32((y * 64'sd16777216) / z);
    xd = nx;
    yd = ny;
    if (cam_dist) begin
      k1 = cam_k1; k2 = cam_k2; k3 = cam_k3;
      p1 = $signed(cam_tang[63:32]);
      p2 = $signed(cam_tang[31:0]);
      sq = 64'(nx * nx) + 64'(ny * ny);
      r2 = clamp32(longint'(sq >> 24));
      r4 = clamp32((r2 * r2) >>> 24);
      r6 = clamp32((r2 * r4) >>> 24);
      xx = clamp32((nx * nx) >>> 24);
      yy = clamp32((ny * ny) >>> 24);
      xy = clamp32((nx * ny) >>> 24);
      rad = clamp32(64'sd16777216 + ((k1 * r2) >>> 28) + ((k2 * r4) >>> 28)
                    + ((k3 * r6) >>> 28));
      tx = clamp32(r2 + 2 * xx);
      ty = clamp32(r2 + 2 * yy);
      dx = 2 * ((p1 * xy) >>> 28) + ((p2 * tx) >>> 28);
      dy = ((p1 * ty) >>> 28) + 2 * ((p2 * xy) >>> 28);
      xd = clamp32(((nx * rad) >>> 24) + dx);
      yd = clamp32(((ny * rad) >>> 24) + dy);
    end
    fx = longint'({32'b0, cam_focal[63:32]});
    fy = longint'({32'b0, cam_focal[31:0]});
    u = clamp32(((fx * xd) >>> 24) + longint'({32'b0, cam_cx}));
    v = clamp32(((fy * yd) >>> 24) + longint'({32'b0, cam_cy}));
    r.u = u[31:0];
    r.v = v[31:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // predictor follows register writes and accepted points; checker pops pixels
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      cam_focal <= FOCAL_RESET;
      cam_cx <= '0; cam_cy <= '0;
      cam_k1 <= '0; cam_k2 <= '0; cam_k3 <= '0;
      cam_tang <= '0;
      cam_dist <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOCAL:   cam_focal <= cfg_data;
          REG_PRIN_X:  cam_cx <= cfg_data[31:0];
          REG_PRIN_Y:  cam_cy <= cfg_data[31:0];
          REG_K1:      cam_k1 <= cfg_data[31:0];
          REG_K2:      cam_k2 <= cfg_data[31:0];
          REG_K3:      cam_k3 <= cfg_data[31:0];
          REG_TANG:    cam_tang <= cfg_data;
          REG_DIST_EN: cam_dist <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pixel_q.push_back(fix_en ? fix_px : project(point_x, point_y, point_z));
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected pixel u=%h v=%h ok=%b", pixel_u, pixel_v, point_valid);
          end
        end else begin
          e = pixel_q.pop_front();
          if (pixel_u !== e.u || pixel_v !== e.v || point_valid !== e.ok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel mismatch: exp u=%h v=%h ok=%b, got u=%h v=%h ok=%b",
                       e.u, e.v, e.ok, pixel_u, pixel_v, point_valid);
            end
          end
        end
      end
    end
  end

  // receiver: stall pattern switches at random among four modes, plus one long hold-off
  int stall_mode = 0;
  int stall_cyc = 0;
  int hold_cnt = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 64 == 63) stall_mode <= $urandom_range(0, 3);
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt <= HOLD_LEN;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= (hold_cnt > 1);
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_cyc % 3 == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no traffic on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_camera_point_projection_core failed");
        $finish;
      end
    end
  end

  int burst_left = 0;

  // one point; the sender keeps valid high across a burst
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic fixed,
                            input pixel_t px, input logic gaps);
    int gap;
    if (gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    fix_en <= fixed;
    fix_px <= px;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    fix_en <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // valid drops for one cycle after each write
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_points(input int count, input logic gaps);
    logic signed [31:0] x, y, z;
    int sel, sh;
    pixel_t none;
    none = '{u: '0, v: '0, ok: 1'b0};
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      sh = $urandom_range(0, 30);
      if (sel == 0) begin
        // raw noise, any depth
        x = $urandom; y = $urandom; z = $urandom;
      end else if (sel == 1) begin
        x = $urandom; y = $urandom;
        z = -$signed(32'($urandom_range(0, 1000)));
      end else begin
        // points in front of the camera, mostly within a moderate field of view
        z = 32'(($urandom >> sh) | 1);
        x = 32'($signed(32'($urandom)) >>> ($urandom_range(0, 31)));
        y = 32'($signed(32'($urandom)) >>> ($urandom_range(0, 31)));
        if (sel < 8) begin
          x = 32'($signed(64'(x) % (64'(z) * 2 + 1)));
          y = 32'($signed(64'(y) % (64'(z) * 2 + 1)));
        end
      end
      send_point(x, y, z, 1'b0, none, gaps);
    end
  endtask

  point_row_t rows[$];
  pixel_t bad_px, zero_px, none_px, unit_px;

  initial begin
    bad_px  = '{u: -32'sd65536, v: -32'sd65536, ok: 1'b0};
    zero_px = '{u: '0, v: '0, ok: 1'b1};
    unit_px = '{u: 32'sd65536, v: 32'sd65536, ok: 1'b1};
    none_px = '{u: '0, v: '0, ok: 1'b0};
    rows = '{
      '{x: 0, y: 0, z: 0, fixed: 1, px: bad_px},
      '{x: 100, y: -5, z: -1, fixed: 1, px: bad_px},
      '{x: S32_MAX, y: S32_MIN, z: S32_MIN, fixed: 1, px: bad_px},
      '{x: 0, y: 0, z: 1, fixed: 1, px: zero_px},
      '{x: 65536, y: 65536, z: 65536, fixed: 1, px: unit_px},
      '{x: S32_MAX, y: S32_MIN, z: 1, fixed: 0, px: none_px},
      '{x: S32_MIN, y: S32_MAX, z: 1, fixed: 0, px: none_px},
      '{x: S32_MAX, y: S32_MAX, z: S32_MAX, fixed: 0, px: none_px},
      '{x: S32_MIN, y: S32_MIN, z: S32_MAX, fixed: 0, px: none_px},
      '{x: -1, y: 1, z: S32_MAX, fixed: 0, px: none_px},
      '{x: 127 * 65536, y: -128 * 65536, z: 65536, fixed: 0, px: none_px},
      '{x: 3, y: -7, z: 2, fixed: 0, px: none_px},
      '{x: 32'h5555_5555, y: 32'haaaa_aaaa, z: 32'h0000_ffff, fixed: 0, px: none_px}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].fixed,
                                 rows[i].px, 1'b0);
    random_points(150, 1'b1);
    drain_points();

    // lens without distortion, random camera
    write_reg(REG_FOCAL, {32'($urandom_range(100, 2000)) << 16,
                          32'($urandom_range(100, 2000)) << 16});
    write_reg(REG_PRIN_X, 32'($urandom_range(0, 1000)) << 16);
    write_reg(REG_PRIN_Y, 32'($urandom_range(0, 1000)) << 16);
    random_points(150, 1'b1);
    drain_points();

    // distortion on, all coefficients zero: identity
    write_reg(REG_DIST_EN, 64'd1);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, none_px, 1'b0);
    // long output hold-off while the sender keeps offering points
    hold_req <= 1'b1;
    random_points(150, 1'b0);
    drain_points();

    // typical lens coefficients, with one full drain in the middle
    write_reg(REG_K1, 64'($signed(-32'sd26843546)));
    write_reg(REG_K2, 64'(32'sd5368709));
    write_reg(REG_K3, 64'($signed(-32'sd268435)));
    write_reg(REG_TANG, {32'sd268435, -32'sd134217});
    random_points(100, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    random_points(100, 1'b1);
    drain_points();

    // random coefficients at every phase
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_FOCAL, {32'($urandom), 32'($urandom)});
      write_reg(REG_PRIN_X, 32'($urandom));
      write_reg(REG_PRIN_Y, 32'($urandom));
      write_reg(REG_K1, 64'($urandom));
      write_reg(REG_K2, 64'($urandom));
      write_reg(REG_K3, 64'($urandom));
      write_reg(REG_TANG, {32'($urandom), 32'($urandom)});
      write_reg(REG_DIST_EN, 64'($urandom));
      random_points(120, 1'b1);
      drain_points();
    end

    // extremes: largest focal and principal point, coefficients at both ends
    write_reg(REG_DIST_EN, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_FOCAL, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_PRIN_X, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_PRIN_Y, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_K1, 64'(S32_MAX));
    write_reg(REG_K2, 64'(S32_MAX));
    write_reg(REG_K3, 64'(S32_MAX));
    write_reg(REG_TANG, {S32_MAX, S32_MAX});
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, none_px, 1'b0);
    random_points(80, 1'b1);
    drain_points();

    write_reg(REG_K1, 64'(S32_MIN));
    write_reg(REG_K2, 64'(S32_MIN));
    write_reg(REG_K3, 64'(S32_MIN));
    write_reg(REG_TANG, {S32_MIN, S32_MIN});
    write_reg(REG_PRIN_X, 64'd0);
    write_reg(REG_PRIN_Y, 64'd0);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, none_px, 1'b0);
    random_points(80, 1'b1);
    drain_points();

    // zero focal lengths collapse every point of valid depth onto the principal point
    write_reg(REG_FOCAL, 64'd0);
    write_reg(REG_DIST_EN, 64'd0);
    random_points(60, 1'b1);
    drain_points();

    if (mismatches == 0) begin
      $display("tb_camera_point_projection_core passed");
    end else begin
      $display("tb_camera_point_projection_core failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cpp_pkg.sv
hw/rtl/camera_point_projection_core.sv
test/tb_camera_point_projection_core.sv
